// ===== rtl/mclg_pkg.sv =====
// mclg_pkg: shared widths and defaults for the mip chain layout generator
// no dependencies
`default_nettype none

package mclg_pkg;

  localparam int DEF_MAX_LEVELS  = 15;
  localparam int DEF_EXTENT_BITS = 14;

  localparam int TYPE_W    = 2;
  localparam int LVL_W     = 4;
  localparam int LVL_CMP_W = LVL_W + 1;
  localparam int LAYER_W   = 12;
  localparam int SAMPLE_W  = 7;
  localparam int DEN_W     = 4;
  localparam int BYTES_W   = 5;

  localparam int ROW_OUT_W   = 25;
  localparam int SLICE_OUT_W = 39;
  localparam int OFF_W       = 52;

  localparam logic [TYPE_W-1:0] TYPE_3D = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/mip_chain_layout_generator_unit.sv =====
// mip_chain_layout_generator_unit: sequencer around a shared divider and multiplier
// depends on mclg_pkg, mclg_div, mclg_mul
// each level divides width and height on the bit-serial divider, then runs the multiply chain
//   and emits once the output register is free (out_ready may stall the emit)
// one item at a time: not ready again until the last level has been emitted
// reset: synchronous active low, returns to idle with no result pending
`default_nettype none

module mip_chain_layout_generator_unit
  import mclg_pkg::*;
#(
  parameter int MAX_LEVELS  = DEF_MAX_LEVELS,
  parameter int EXTENT_BITS = DEF_EXTENT_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [TYPE_W-1:0]      in_image_type,
  input  wire logic [EXTENT_BITS:0]   in_base_width,
  input  wire logic [EXTENT_BITS:0]   in_base_height,
  input  wire logic [EXTENT_BITS:0]   in_base_depth,
  input  wire logic [LVL_W-1:0]       in_level_count,
  input  wire logic [LAYER_W-1:0]     in_layer_count,
  input  wire logic [SAMPLE_W-1:0]    in_samples,
  input  wire logic [DEN_W-1:0]       in_block_w,
  input  wire logic [DEN_W-1:0]       in_block_h,
  input  wire logic [BYTES_W-1:0]     in_block_bytes,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [LVL_W-1:0]            out_level_index,
  output logic [OFF_W-1:0]            out_level_offset,
  output logic [BYTES_W-1:0]          out_sample_step,
  output logic [ROW_OUT_W-1:0]        out_row_stride,
  output logic [SLICE_OUT_W-1:0]      out_slice_stride,
  output logic [OFF_W-1:0]            out_end_offset,
  output logic                        out_last_level
);

  localparam int XW  = EXTENT_BITS + 1;
  localparam int RW  = XW + BYTES_W + SAMPLE_W;
  localparam int SW  = RW + XW;
  localparam int SLW = (XW > LAYER_W) ? XW : LAYER_W;
  localparam int MA  = RW;
  localparam int MB  = SLW;
  localparam int PW  = MA + MB;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_DIV_W,
    ST_DIV_H,
    ST_MUL_WB,
    ST_MUL_S,
    ST_MUL_H,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC_HI,
    ST_EMIT
  } state_t;

  state_t state_r;

  logic                is3d_r;
  logic [XW-1:0]       bw_r;
  logic [XW-1:0]       bh_r;
  logic [XW-1:0]       bd_r;
  logic [LVL_W-1:0]    count_r;
  logic [LVL_W-1:0]    lv_r;
  logic [LAYER_W-1:0]  layers_r;
  logic [SAMPLE_W-1:0] samples_r;
  logic [DEN_W-1:0]    blkw_r;
  logic [DEN_W-1:0]    blkh_r;
  logic [BYTES_W-1:0]  bytes_r;
  logic [XW-1:0]       wide_r;
  logic [XW-1:0]       high_r;
  logic [RW-1:0]       row_r;
  logic [SW-1:0]       slice_r;
  logic [OFF_W-1:0]    base_off_r;
  logic [OFF_W-1:0]    acc_r;

  logic                out_valid_r;
  logic [LVL_W-1:0]    out_level_index_r;
  logic [OFF_W-1:0]    out_level_offset_r;
  logic [BYTES_W-1:0]  out_sample_step_r;
  logic [ROW_OUT_W-1:0]   out_row_stride_r;
  logic [SLICE_OUT_W-1:0] out_slice_stride_r;
  logic [OFF_W-1:0]    out_end_offset_r;
  logic                out_last_level_r;

  logic [XW-1:0]       w_shift;
  logic [XW-1:0]       h_shift;
  logic [XW-1:0]       d_shift;
  logic [XW-1:0]       w_lvl;
  logic [XW-1:0]       h_lvl;
  logic [SLW-1:0]      slices;
  logic [LVL_W-1:0]    count_clamped;
  logic                is_last;
  logic                out_free;

  logic                div_start;
  logic [XW-1:0]       div_num;
  logic [DEN_W-1:0]    div_den;
  logic                div_done;
  logic [XW-1:0]       div_quo;
  logic [DEN_W-1:0]    div_rem;
  logic [XW-1:0]       div_ceil;

  logic [MA-1:0]       mul_a;
  logic [MB-1:0]       mul_b;
  logic [PW-1:0]       mul_p;

  always_comb begin
    w_shift = bw_r >> lv_r;
    h_shift = bh_r >> lv_r;
    d_shift = bd_r >> lv_r;
    w_lvl   = (w_shift == '0) ? XW'(1) : w_shift;
    h_lvl   = (h_shift == '0) ? XW'(1) : h_shift;
    if (is3d_r) begin
      slices = (d_shift == '0) ? SLW'(1) : SLW'(d_shift);
    end else begin
      slices = SLW'(layers_r);
    end
    if ({1'b0, in_level_count} > LVL_CMP_W'(MAX_LEVELS)) begin
      count_clamped = LVL_W'(MAX_LEVELS);
    end else begin
      count_clamped = in_level_count;
    end
    is_last  = (lv_r == count_r - 1'b1);
    out_free = !out_valid_r || out_ready;
    div_ceil = div_quo + XW'(div_rem != '0);
  end

  assign div_start = (state_r == ST_LEVEL) || ((state_r == ST_DIV_W) && div_done);
  assign div_num   = (state_r == ST_DIV_W) ? h_lvl : w_lvl;
  assign div_den   = (state_r == ST_DIV_W) ? blkh_r : blkw_r;

  always_comb begin
    mul_a = MA'(wide_r);
    mul_b = MB'(bytes_r);
    unique case (state_r)
      ST_MUL_S: begin
        mul_a = MA'(mul_p);
        mul_b = MB'(samples_r);
      end
      ST_MUL_H: begin
        mul_a = MA'(mul_p);
        mul_b = MB'(high_r);
      end
      ST_MUL_LO: begin
        mul_a = MA'(mul_p);
        mul_b = slices;
      end
      ST_MUL_HI: begin
        mul_a = MA'(slice_r[SW-1:MA]);
        mul_b = slices;
      end
      default: begin
        mul_a = MA'(wide_r);
        mul_b = MB'(bytes_r);
      end
    endcase
  end

  mclg_div #(
    .NUM_W (XW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  mclg_mul #(
    .A_W (MA),
    .B_W (MB)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            is3d_r     <= (in_image_type == TYPE_3D);
            bw_r       <= in_base_width;
            bh_r       <= in_base_height;
            bd_r       <= in_base_depth;
            count_r    <= count_clamped;
            lv_r       <= '0;
            layers_r   <= in_layer_count;
            samples_r  <= in_samples;
            blkw_r     <= (in_block_w == '0) ? DEN_W'(1) : in_block_w;
            blkh_r     <= (in_block_h == '0) ? DEN_W'(1) : in_block_h;
            bytes_r    <= in_block_bytes;
            base_off_r <= '0;
            acc_r      <= '0;
            if (count_clamped != '0) begin
              state_r <= ST_LEVEL;
            end
          end
        end
        ST_LEVEL: begin
          state_r <= ST_DIV_W;
        end
        ST_DIV_W: begin
          if (div_done) begin
            wide_r  <= div_ceil;
            state_r <= ST_DIV_H;
          end
        end
        ST_DIV_H: begin
          if (div_done) begin
            high_r  <= div_ceil;
            state_r <= ST_MUL_WB;
          end
        end
        ST_MUL_WB: begin
          state_r <= ST_MUL_S;
        end
        ST_MUL_S: begin
          state_r <= ST_MUL_H;
        end
        ST_MUL_H: begin
          row_r   <= RW'(mul_p);
          state_r <= ST_MUL_LO;
        end
        ST_MUL_LO: begin
          slice_r <= SW'(mul_p);
          state_r <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          acc_r   <= acc_r + OFF_W'(mul_p);
          state_r <= ST_ACC_HI;
        end
        ST_ACC_HI: begin
          acc_r   <= acc_r + (OFF_W'(mul_p) << MA);
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r        <= 1'b1;
            out_level_index_r  <= lv_r;
            out_level_offset_r <= base_off_r;
            out_sample_step_r  <= (samples_r > SAMPLE_W'(1)) ? bytes_r : '0;
            out_row_stride_r   <= ROW_OUT_W'(row_r);
            out_slice_stride_r <= SLICE_OUT_W'(slice_r);
            out_end_offset_r   <= acc_r;
            out_last_level_r   <= is_last;
            base_off_r         <= acc_r;
            lv_r               <= lv_r + 1'b1;
            state_r            <= is_last ? ST_IDLE : ST_LEVEL;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_level_index  = out_level_index_r;
  assign out_level_offset = out_level_offset_r;
  assign out_sample_step  = out_sample_step_r;
  assign out_row_stride   = out_row_stride_r;
  assign out_slice_stride = out_slice_stride_r;
  assign out_end_offset   = out_end_offset_r;
  assign out_last_level   = out_last_level_r;

endmodule

`default_nettype wire

// ===== rtl/mclg_div.sv =====
// mclg_div: iterative restoring divider, one quotient bit per cycle
// depends on mclg_pkg
`default_nettype none

module mclg_div
  import mclg_pkg::*;
#(
  parameter int NUM_W = DEF_EXTENT_BITS + 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo,
  output logic [DEN_W-1:0]      rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        quo_r <= {quo_r[NUM_W-2:0], ge};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ===== rtl/mclg_mul.sv =====
// mclg_mul: shared unsigned multiplier with registered product
// depends on mclg_pkg
`default_nettype none

module mclg_mul
  import mclg_pkg::*;
#(
  parameter int A_W = DEF_EXTENT_BITS + 13,
  parameter int B_W = DEF_EXTENT_BITS + 1
) (
  input  wire logic             clk,
  input  wire logic [A_W-1:0]   a,
  input  wire logic [B_W-1:0]   b,
  output logic [A_W+B_W-1:0]    p
);

  logic [A_W+B_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= (A_W + B_W)'(a) * (A_W + B_W)'(b);
  end

  assign p = p_r;

endmodule

`default_nettype wire
